// ===== hdl/dws_pkg.sv =====
`timescale 1ns / 1ps

package dws_pkg;

  localparam int unsigned ACT_W = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned OCC_W = 5;

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [ST_W-1:0]  status;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_search;
    logic cnt_zero;
    logic rem_zero;
    logic rd_pend;
    logic hit;
  } sts_t;

endpackage

// ===== hdl/dws_ram.sv =====
`timescale 1ns / 1ps

module dws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/dws_datapath.sv =====
`timescale 1ns / 1ps

module dws_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dws_pkg::req_t req_i,
  input  dws_pkg::cmd_t cmd_i,
  output dws_pkg::sts_t sts_o,
  output logic          valid_o,
  output dws_pkg::rsp_t rsp_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [PW-1:0]  head_q, head_d;
  logic [CW-1:0]  count_q, count_d;
  logic [PW-1:0]  sp_q, sp_d;
  logic [CW-1:0]  rem_q, rem_d;
  logic           rd_pend_q, rd_pend_d;
  logic           valid_q, valid_d;
  dws_pkg::req_t  req_q, req_d;
  dws_pkg::rsp_t  rsp_q, rsp_d;

  logic                     we, re;
  logic [PW-1:0]            waddr;
  logic [PW:0]              back_sum;
  logic [PW-1:0]            back_pos, head_m1, head_p1, sp_p1;
  logic [dws_pkg::VAL_W-1:0] rdata;
  logic                     full, empty, hit;
  logic [dws_pkg::ST_W-1:0] status;

  assign full     = (count_q == FULL_CNT);
  assign empty    = (count_q == '0);
  assign head_m1  = (head_q == '0) ? LAST : head_q - PW'(1);
  assign head_p1  = (head_q == LAST) ? '0 : head_q + PW'(1);
  assign sp_p1    = (sp_q == LAST) ? '0 : sp_q + PW'(1);
  assign back_sum = {1'b0, head_q} + (PW + 1)'(count_q);
  assign back_pos = (back_sum >= (PW + 1)'(DEPTH)) ? PW'(back_sum - (PW + 1)'(DEPTH))
                                                   : back_sum[PW-1:0];
  assign hit      = rd_pend_q && (rdata == req_q.value);

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    sp_d      = sp_q;
    rem_d     = rem_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    valid_d   = 1'b0;
    rd_pend_d = 1'b0;
    we        = 1'b0;
    waddr     = back_pos;
    re        = 1'b0;
    status    = dws_pkg::ST_DONE;

    if (cmd_i.load) begin
      req_d = req_i;
      sp_d  = head_q;
      rem_d = count_q;
    end

    if (cmd_i.exec) begin
      case (req_q.action)
        dws_pkg::ACT_PUSH_FRONT: begin
          if (full) begin
            status = dws_pkg::ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = head_m1;
            head_d  = head_m1;
            count_d = count_q + CW'(1);
          end
        end
        dws_pkg::ACT_PUSH_BACK: begin
          if (full) begin
            status = dws_pkg::ST_FULL;
          end else begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        dws_pkg::ACT_POP_FRONT: begin
          if (empty) begin
            status = dws_pkg::ST_EMPTY;
          end else begin
            head_d  = head_p1;
            count_d = count_q - CW'(1);
          end
        end
        dws_pkg::ACT_POP_BACK: begin
          if (empty) begin
            status = dws_pkg::ST_EMPTY;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
        default: begin
        end
      endcase
      valid_d         = 1'b1;
      rsp_d.found     = 1'b0;
      rsp_d.status    = status;
      rsp_d.occupancy = dws_pkg::OCC_W'(count_d);
    end

    if (cmd_i.step && (rem_q != '0)) begin
      re        = 1'b1;
      rd_pend_d = 1'b1;
      sp_d      = sp_p1;
      rem_d     = rem_q - CW'(1);
    end

    if (cmd_i.finish) begin
      valid_d         = 1'b1;
      rsp_d.found     = hit;
      rsp_d.status    = dws_pkg::ST_DONE;
      rsp_d.occupancy = dws_pkg::OCC_W'(count_q);
    end
  end

  dws_ram #(
    .WIDTH(dws_pkg::VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(req_q.value),
    .re_i   (re),
    .raddr_i(sp_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      rem_q     <= '0;
      rd_pend_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      head_q    <= head_d;
      count_q   <= count_d;
      rem_q     <= rem_d;
      rd_pend_q <= rd_pend_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q  <= sp_d;
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  assign sts_o.is_search = (req_q.action == dws_pkg::ACT_SEARCH);
  assign sts_o.cnt_zero  = empty;
  assign sts_o.rem_zero  = (rem_q == '0);
  assign sts_o.rd_pend   = rd_pend_q;
  assign sts_o.hit       = hit;
  assign valid_o         = valid_q;
  assign rsp_o           = rsp_q;

endmodule

// ===== hdl/dws_ctrl.sv =====
`timescale 1ns / 1ps

module dws_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dws_pkg::sts_t sts_i,
  output dws_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    IDLE,
    DECODE,
    SEARCH
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   search_end;

  assign search_end = sts_i.hit || (sts_i.rem_zero && !sts_i.rd_pend);

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    cmd_o   = '0;
    case (state_q)
      IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = DECODE;
          busy_d     = 1'b1;
        end
      end
      DECODE: begin
        if (sts_i.is_search && !sts_i.cnt_zero) begin
          state_d = SEARCH;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = IDLE;
          busy_d     = 1'b0;
        end
      end
      SEARCH: begin
        if (search_end) begin
          cmd_o.finish = 1'b1;
          state_d      = IDLE;
          busy_d       = 1'b0;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

endmodule

// ===== hdl/deque_with_search.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of 32-bit values with a linear search.
// Command channel: drive req_i and raise start; the item transfers on a
// rising edge with start high and busy low. busy stays high until the
// result is issued.
// Result channel: out_valid_o is high for exactly one cycle with rsp_o
// (found, status, occupancy); the receiver cannot stall, so the result
// transfers at the end of that cycle.
// Push, pop and unused actions finish without a search; a search walks
// the stored entries with the single RAM read port, one stored entry
// per cycle from the head, stopping early on a match; a search of an
// empty queue finishes without a walk.
// The next item may start in the cycle the result is shown.
// Reset clears head, count and all control state; the queue is empty.
// Entry storage is not cleared and is only read where written.
module deque_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dws_pkg::req_t req_i,
  output logic          out_valid_o,
  output dws_pkg::rsp_t rsp_o
);

  dws_pkg::cmd_t cmd;
  dws_pkg::sts_t sts;

  dws_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  dws_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .valid_o(out_valid_o),
    .rsp_o  (rsp_o)
  );

endmodule
